// ===== hdl/brsd_pkg.sv =====
// ----------------------------------------------------------------------------
// brsd_pkg: shared types and constants for the block descrambler
// Sizes of the block store, the key seed, operation codes and the packed
// request and response item types.
// ----------------------------------------------------------------------------
package brsd_pkg;

	localparam int MAX_BLOCK = 1024;
	localparam int ADDR_W    = $clog2(MAX_BLOCK);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int KEY_W     = 32;
	localparam int DCNT_W    = $clog2(KEY_W);

	localparam logic [KEY_W-1:0] KEY_SEED = 32'h6267_7079;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
		logic       last;
		logic [9:0] read_index;
	} req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        read_valid;
		logic [10:0] block_length;
		logic        overflow;
	} rsp_t;

endpackage

// ===== hdl/block_rotate_swap_descrambler_unit.sv =====
// ----------------------------------------------------------------------------
// block_rotate_swap_descrambler_unit: rotate-and-swap block descrambler
//
//   channel | signals                        | transfer when
//   --------+--------------------------------+---------------------------
//   req     | req_valid, req_stall, req_data | req_valid && !req_stall
//   rsp     | rsp_valid, rsp_stall, rsp_data | rsp_valid && !rsp_stall
//
// A load without last gives its registered response in the cycle after the
// transfer, and the unit stays idle for the next request. A read passes
// through S_RD, where the registered RAM data goes into the response. A load
// marked last, in a block of two bytes or more, first runs the descramble: a
// backward key pass, then a forward pass that swaps each byte with an earlier
// one. The forward pass forms the remainder bit-serially (one quotient bit
// per cycle over the 32-bit key) and shares the single RAM read port.
// Reset clears the control state only; the block RAM has no clearing pass.
// A waiting response that is stalled holds up the next request until it is taken.
// ----------------------------------------------------------------------------
module block_rotate_swap_descrambler_unit
	import brsd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_RD      = 4'd1;
	localparam logic [3:0] S_BK_ADDR = 4'd2;
	localparam logic [3:0] S_BK_DATA = 4'd3;
	localparam logic [3:0] S_FW_RDI  = 4'd4;
	localparam logic [3:0] S_FW_KEY  = 4'd5;
	localparam logic [3:0] S_FW_DIV  = 4'd6;
	localparam logic [3:0] S_FW_RDJ  = 4'd7;
	localparam logic [3:0] S_FW_WRJ  = 4'd8;
	localparam logic [3:0] S_FW_WRI  = 4'd9;

	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(KEY_W - 1);

	logic [3:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	logic              ovf_q;
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;
	logic              rd_ok_q;

	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  dvd_q;
	logic [ADDR_W-1:0] rem_q;
	logic [ADDR_W-1:0] i_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [7:0]        bi_q;
	logic [7:0]        held_q;

	logic              accept;
	logic [CNT_W-1:0]  cnt_base;
	logic              has_room;
	logic [CNT_W-1:0]  cnt_new;
	logic              ovf_new;
	logic              rd_ok;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	logic [KEY_W-1:0]  rdata_ext;
	logic [KEY_W-1:0]  key_back;
	logic [KEY_W-1:0]  key_xor;
	logic [KEY_W-1:0]  key_fwd;
	logic [ADDR_W:0]   trial;
	logic [ADDR_W:0]   divisor;
	logic [ADDR_W:0]   diff;
	logic [ADDR_W-1:0] rem_next;
	logic              last_step;

	logic              rsp_load;
	rsp_t              rsp_next;

	assign req_stall = !((state_q == S_IDLE) && (!rsp_valid_q || !rsp_stall));
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// A load after a finished block starts a fresh one.
	assign cnt_base = done_q ? '0 : count_q;
	assign has_room = cnt_base < CNT_W'(MAX_BLOCK);
	assign cnt_new  = has_room ? cnt_base + 1'b1 : cnt_base;
	assign ovf_new  = !has_room || (!done_q && ovf_q);
	assign rd_ok    = done_q && (CNT_W'(req_data.read_index) < count_q);

	assign rdata_ext = {{(KEY_W-8){1'b0}}, rdata};
	assign key_back  = {key_q[KEY_W-2:0], key_q[KEY_W-1]} ^ rdata_ext;
	assign key_xor   = key_q ^ rdata_ext;
	assign key_fwd   = {key_xor[0], key_xor[KEY_W-1:1]};

	// One restoring step of key mod i per cycle; the remainder stays below i.
	assign trial     = {rem_q, dvd_q[KEY_W-1]};
	assign divisor   = {1'b0, i_q};
	assign diff      = trial - divisor;
	assign rem_next  = (trial >= divisor) ? diff[ADDR_W-1:0] : trial[ADDR_W-1:0];
	assign last_step = (divisor + 1'b1) == count_q;

	always_comb begin
		we    = 1'b0;
		waddr = i_q;
		wdata = held_q;
		raddr = i_q;
		case (state_q)
			S_IDLE: begin
				raddr = ADDR_W'(req_data.read_index);
				if (accept && req_data.opcode == OP_LOAD && has_room) begin
					we    = 1'b1;
					waddr = cnt_base[ADDR_W-1:0];
					wdata = req_data.data_byte;
				end
			end
			S_FW_RDJ: begin
				raddr = rem_q;
			end
			S_FW_WRJ: begin
				we    = 1'b1;
				waddr = rem_q;
				wdata = rdata ^ ~bi_q;
			end
			S_FW_WRI: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = held_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp_load              = 1'b0;
		rsp_next.read_data    = '0;
		rsp_next.read_valid   = 1'b0;
		rsp_next.block_length = 11'(count_q);
		rsp_next.overflow     = ovf_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req_data.opcode == OP_LOAD) begin
					rsp_next.block_length = 11'(cnt_new);
					rsp_next.overflow     = ovf_new;
					rsp_load = !req_data.last || (cnt_new < CNT_W'(2));
				end
			end
			S_RD: begin
				rsp_load            = 1'b1;
				rsp_next.read_valid = rd_ok_q;
				rsp_next.read_data  = rd_ok_q ? rdata : '0;
			end
			S_FW_WRI: begin
				rsp_load = last_step;
			end
			default: begin
			end
		endcase
	end

	brsd_ram #(
		.WIDTH(8),
		.DEPTH(MAX_BLOCK)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			done_q      <= 1'b0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_data.opcode == OP_READ) begin
							state_q <= S_RD;
						end else begin
							count_q <= cnt_new;
							ovf_q   <= ovf_new;
							done_q  <= req_data.last;
							if (req_data.last && cnt_new >= CNT_W'(2)) begin
								state_q <= S_BK_ADDR;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_IDLE;
				end
				S_BK_ADDR: begin
					state_q <= S_BK_DATA;
				end
				S_BK_DATA: begin
					state_q <= (i_q == ADDR_W'(1)) ? S_FW_RDI : S_BK_ADDR;
				end
				S_FW_RDI: begin
					state_q <= S_FW_KEY;
				end
				S_FW_KEY: begin
					state_q <= S_FW_DIV;
				end
				S_FW_DIV: begin
					if (dcnt_q == DIV_LAST) begin
						state_q <= S_FW_RDJ;
					end
				end
				S_FW_RDJ: begin
					state_q <= S_FW_WRJ;
				end
				S_FW_WRJ: begin
					state_q <= S_FW_WRI;
				end
				S_FW_WRI: begin
					state_q <= last_step ? S_IDLE : S_FW_RDI;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_data_q <= rsp_next;
		end
		case (state_q)
			S_IDLE: begin
				rd_ok_q <= rd_ok;
				i_q     <= ADDR_W'(cnt_new - 1'b1);
				key_q   <= KEY_SEED;
			end
			S_BK_DATA: begin
				key_q <= key_back;
				if (i_q != ADDR_W'(1)) begin
					i_q <= i_q - 1'b1;
				end
			end
			S_FW_KEY: begin
				bi_q   <= rdata;
				key_q  <= key_fwd;
				dvd_q  <= key_fwd;
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			S_FW_DIV: begin
				rem_q  <= rem_next;
				dvd_q  <= {dvd_q[KEY_W-2:0], 1'b0};
				dcnt_q <= dcnt_q + 1'b1;
			end
			S_FW_WRJ: begin
				held_q <= rdata;
			end
			S_FW_WRI: begin
				i_q <= i_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/brsd_ram.sv =====
// ----------------------------------------------------------------------------
// brsd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/brsd_checker.sv =====
// ----------------------------------------------------------------------------
// brsd_checker: port-level checks for the block descrambler
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module brsd_checker
	import brsd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req_data,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_data
);

	// A stalled response stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	// A read that misses returns zero data.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.read_valid |-> rsp_data.read_data == 8'd0)
		else $error("invalid read returned nonzero data");

	// The reported length never exceeds the block store.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.block_length <= 11'(MAX_BLOCK))
		else $error("block length beyond store size");

	// A read transfer keeps the request side busy while the store is read.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.opcode == OP_READ |=> req_stall)
		else $error("request taken during a store read");

endmodule

bind block_rotate_swap_descrambler_unit brsd_checker u_brsd_checker (.*);

// ===== bench/block_rotate_swap_descrambler_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_rotate_swap_descrambler_unit_test: self-checking bench for the descrambler
// Sends loads and reads with random gaps on the request side and random stalls
// on the response side. A shadow copy of the block and its descramble gives
// each response not typed into a directed row; all are compared field by field when taken.
// ----------------------------------------------------------------------------
module block_rotate_swap_descrambler_unit_test;
	import brsd_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RANDOM_ITEMS = 60;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 64;
	localparam int STUCK_LIMIT  = 200000;

	// A row either carries its response typed in or takes it from the shadow model.
	localparam logic ROW_TYPED = 1'b1;
	localparam logic ROW_MODEL = 1'b0;

	typedef struct packed {
		req_t req;
		logic mode;
		rsp_t rsp;
	} stim_row_t;

	localparam int N_ROWS = 25;
	// request: opcode, data_byte, last, read_index | mode | read_data, read_valid,
	// block_length, overflow
	localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
		{OP_READ, 8'h00, 1'b0, 10'd0,    ROW_TYPED, 8'h00, 1'b0, 11'd0, 1'b0},
		{OP_READ, 8'hFF, 1'b1, 10'd1023, ROW_TYPED, 8'h00, 1'b0, 11'd0, 1'b0},
		{OP_LOAD, 8'hFF, 1'b1, 10'd1023, ROW_TYPED, 8'h00, 1'b0, 11'd1, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd0,    ROW_TYPED, 8'hFF, 1'b1, 11'd1, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd1,    ROW_TYPED, 8'h00, 1'b0, 11'd1, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd1023, ROW_TYPED, 8'h00, 1'b0, 11'd1, 1'b0},
		{OP_LOAD, 8'h00, 1'b0, 10'd0,    ROW_TYPED, 8'h00, 1'b0, 11'd1, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd0,    ROW_TYPED, 8'h00, 1'b0, 11'd1, 1'b0},
		{OP_LOAD, 8'h5A, 1'b1, 10'd0,    ROW_TYPED, 8'h00, 1'b0, 11'd2, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd0,    ROW_MODEL, 8'h00, 1'b0, 11'd0, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd1,    ROW_MODEL, 8'h00, 1'b0, 11'd0, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd2,    ROW_TYPED, 8'h00, 1'b0, 11'd2, 1'b0},
		{OP_LOAD, 8'h00, 1'b0, 10'd0,    ROW_TYPED, 8'h00, 1'b0, 11'd1, 1'b0},
		{OP_LOAD, 8'hFF, 1'b0, 10'd512,  ROW_TYPED, 8'h00, 1'b0, 11'd2, 1'b0},
		{OP_LOAD, 8'h80, 1'b0, 10'd0,    ROW_TYPED, 8'h00, 1'b0, 11'd3, 1'b0},
		{OP_LOAD, 8'h01, 1'b0, 10'd0,    ROW_TYPED, 8'h00, 1'b0, 11'd4, 1'b0},
		{OP_LOAD, 8'hC3, 1'b1, 10'd0,    ROW_TYPED, 8'h00, 1'b0, 11'd5, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd0,    ROW_MODEL, 8'h00, 1'b0, 11'd0, 1'b0},
		{OP_READ, 8'hFF, 1'b1, 10'd1,    ROW_MODEL, 8'h00, 1'b0, 11'd0, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd2,    ROW_MODEL, 8'h00, 1'b0, 11'd0, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd3,    ROW_MODEL, 8'h00, 1'b0, 11'd0, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd4,    ROW_MODEL, 8'h00, 1'b0, 11'd0, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd5,    ROW_TYPED, 8'h00, 1'b0, 11'd5, 1'b0},
		{OP_LOAD, 8'h00, 1'b1, 10'd0,    ROW_TYPED, 8'h00, 1'b0, 11'd1, 1'b0},
		{OP_READ, 8'h00, 1'b0, 10'd0,    ROW_TYPED, 8'h00, 1'b1, 11'd1, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	// Shadow copy of the block state.
	logic [7:0]  blk_bytes [MAX_BLOCK];
	int unsigned blk_count    = 0;
	bit          blk_done     = 1'b0;
	bit          blk_overflow = 1'b0;

	rsp_t        replies_due [$];
	int unsigned mismatches   = 0;
	int unsigned stuck_cycles = 0;
	bit          send_gaps_on;
	bit          recv_gaps_on;
	bit          hold_off_req = 1'b0;

	block_rotate_swap_descrambler_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void descramble_block(input int unsigned n);
		logic [31:0] key;
		int unsigned i;
		int unsigned j;
		logic [7:0]  held;
		key = KEY_SEED;
		if (n > MAX_BLOCK)
			n = MAX_BLOCK;
		if (n < 2)
			return;
		for (i = n - 1; i != 0; i--)
			key = {key[30:0], key[31]} ^ {24'd0, blk_bytes[i]};
		for (i = 1; i < n; i++) begin
			key = key ^ {24'd0, blk_bytes[i]};
			key = {key[0], key[31:1]};
			j = key % i;
			held = blk_bytes[j];
			blk_bytes[j] = held ^ ~blk_bytes[i];
			blk_bytes[i] = held;
		end
	endfunction

	function automatic rsp_t descramble_step(input req_t r);
		rsp_t o;
		o = '0;
		if (r.opcode == OP_LOAD) begin
			if (blk_done) begin
				blk_count = 0;
				blk_done = 1'b0;
				blk_overflow = 1'b0;
			end
			if (blk_count < MAX_BLOCK) begin
				blk_bytes[blk_count] = r.data_byte;
				blk_count++;
			end else
				blk_overflow = 1'b1;
			if (r.last) begin
				descramble_block(blk_count);
				blk_done = 1'b1;
			end
		end else if (blk_done && r.read_index < blk_count) begin
			o.read_data = blk_bytes[r.read_index];
			o.read_valid = 1'b1;
		end
		o.block_length = 11'(blk_count);
		o.overflow = blk_overflow;
		return o;
	endfunction

	function automatic req_t load_req(input int unsigned data, input bit last,
			input int unsigned idx);
		req_t r;
		r.opcode = OP_LOAD;
		r.data_byte = 8'(data);
		r.last = last;
		r.read_index = 10'(idx);
		return r;
	endfunction

	// The unused load fields of a read carry random values.
	function automatic req_t read_req(input int unsigned idx);
		req_t r;
		r.opcode = OP_READ;
		r.data_byte = 8'($urandom);
		r.last = 1'($urandom);
		r.read_index = 10'(idx);
		return r;
	endfunction

	// Valid stays high between back-to-back transfers; here it only drops for a gap.
	task automatic push_request(input req_t r, input logic mode, input rsp_t typed_rsp);
		int unsigned gap;
		rsp_t due;
		if ($urandom_range(0, 63) == 0)
			send_gaps_on = !send_gaps_on;
		gap = send_gaps_on ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_data <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		due = descramble_step(r);
		replies_due.push_back(mode == ROW_TYPED ? typed_rsp : due);
	endtask

	task automatic drain_replies();
		req_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin : sender
		int unsigned n;
		int unsigned k;
		int unsigned pick;
		int unsigned sent;
		req_valid = 1'b0;
		req_data = '0;
		send_gaps_on = 1'b1;
		@(posedge arst_n);
		@(posedge clk);

		for (int row = 0; row < N_ROWS; row++)
			push_request(DIRECTED_ROWS[row].req, DIRECTED_ROWS[row].mode,
				DIRECTED_ROWS[row].rsp);
		drain_replies();

		// Fill the block to the top while the response side holds off, then
		// drop two bytes, the second one marked last.
		hold_off_req = 1'b1;
		for (int b = 0; b < MAX_BLOCK; b++)
			push_request(load_req($urandom, 1'b0, $urandom), ROW_MODEL, '0);
		push_request(load_req($urandom, 1'b0, $urandom), ROW_MODEL, '0);
		push_request(load_req($urandom, 1'b1, $urandom), ROW_MODEL, '0);
		push_request(read_req(0), ROW_MODEL, '0);
		push_request(read_req(MAX_BLOCK - 1), ROW_MODEL, '0);
		repeat (30)
			push_request(read_req($urandom), ROW_MODEL, '0);
		drain_replies();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
				for (int b = 0; b < n; b++) begin
					if ($urandom_range(0, 19) == 0) begin
						push_request(read_req($urandom), ROW_MODEL, '0);
						sent++;
					end
					push_request(load_req($urandom, b == n - 1, $urandom), ROW_MODEL, '0);
					sent++;
				end
				k = $urandom_range(1, 8);
				repeat (k) begin
					push_request(read_req(($urandom_range(0, 4) == 0) ?
						$urandom_range(n, 1023) : $urandom_range(0, n - 1)), ROW_MODEL, '0);
					sent++;
				end
			end else if (pick < 85) begin
				k = $urandom_range(1, 4);
				repeat (k) begin
					push_request($urandom_range(0, 1) ? read_req($urandom) :
						load_req($urandom, 1'($urandom), $urandom), ROW_MODEL, '0);
					sent++;
				end
			end else begin
				// An unfinished block: loads without last, then reads of it.
				k = $urandom_range(1, 8);
				repeat (k) begin
					push_request(load_req($urandom, 1'b0, $urandom), ROW_MODEL, '0);
					sent++;
				end
				k = $urandom_range(1, 3);
				repeat (k) begin
					push_request(read_req($urandom_range(0, 15)), ROW_MODEL, '0);
					sent++;
				end
			end
		end

		drain_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("block_rotate_swap_descrambler_unit_test OK");
		else
			$display("block_rotate_swap_descrambler_unit_test NOT OK");
		$finish;
	end

	initial begin : receiver
		int unsigned hold;
		rsp_stall = 1'b0;
		recv_gaps_on = 1'b1;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 63) == 0)
				recv_gaps_on = !recv_gaps_on;
			hold = recv_gaps_on ? $urandom_range(0, 6) : 0;
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : reply_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (replies_due.size() == 0) begin
				$error("response transfer with none outstanding: %h", rsp_data);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (rsp_data.read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, rsp_data.read_data);
					mismatches++;
				end
				if (rsp_data.read_valid !== want.read_valid) begin
					$error("read_valid: expected %b, got %b", want.read_valid,
						rsp_data.read_valid);
					mismatches++;
				end
				if (rsp_data.block_length !== want.block_length) begin
					$error("block_length: expected %0d, got %0d", want.block_length,
						rsp_data.block_length);
					mismatches++;
				end
				if (rsp_data.overflow !== want.overflow) begin
					$error("overflow: expected %b, got %b", want.overflow, rsp_data.overflow);
					mismatches++;
				end
			end
		end
	end

	// A full 1024-byte descramble runs with no transfer at all.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			stuck_cycles <= 0;
		else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("block_rotate_swap_descrambler_unit_test NOT OK");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

endmodule
